// File: rtl/core/mdr_pkg.sv
// Shared types, constants and the step function of the duty ramp block.
`timescale 1ns / 1ps
package mdr_pkg;

    localparam int NUM_CHANNELS = 12;
    localparam int DUTY_WIDTH   = 13;
    localparam int CNT_W        = $clog2(NUM_CHANNELS);

    localparam int OP_W       = 3;
    localparam int CH_W       = 4;
    localparam int SP_W       = 8;
    localparam int GAIN_W     = 8;
    localparam int STOP_W     = 13;
    localparam int OUT_DUTY_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 24;

    localparam int SETPOINT_SCALE = 24;
    localparam logic [DUTY_WIDTH-1:0] RESET_DUTY = DUTY_WIDTH'(3000);
    localparam logic [GAIN_W-1:0]     BASE_STEP  = GAIN_W'(1);
    localparam logic [GAIN_W-1:0]     RESET_GAIN = GAIN_W'(1);
    localparam logic [STOP_W-1:0]     RESET_STOP = STOP_W'(3000);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 3'd0,
        OP_SYNC  = 3'd1,
        OP_TICK  = 3'd2,
        OP_START = 3'd3,
        OP_STOP  = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_FIRST  = 2'd0,
        CFG_GAIN_SECOND = 2'd1,
        CFG_STOP_DUTY   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [SP_W-1:0]       staged;
        logic [DUTY_WIDTH-1:0] target;
        logic [DUTY_WIDTH-1:0] duty;
        logic                  enable;
    } chan_t;

    typedef struct packed {
        logic              shift;
        logic              sync;
        logic              start;
        logic              stop;
        logic [STOP_W-1:0] stop_duty;
    } ctrl_t;

    function automatic logic [DUTY_WIDTH-1:0] step_toward(
        input logic [DUTY_WIDTH-1:0] cur,
        input logic [DUTY_WIDTH-1:0] tgt,
        input logic [GAIN_W-1:0]     step
    );
        logic [DUTY_WIDTH:0]   up;
        logic [DUTY_WIDTH-1:0] diff;
        logic [DUTY_WIDTH-1:0] res;
        up   = {1'b0, cur} + (DUTY_WIDTH+1)'(step);
        diff = cur - tgt;
        res  = cur;
        if (tgt > cur) begin
            res = (up > {1'b0, tgt}) ? tgt : up[DUTY_WIDTH-1:0];
        end else if (tgt < cur) begin
            res = (diff <= DUTY_WIDTH'(step)) ? tgt : cur - DUTY_WIDTH'(step);
        end
        return res;
    endfunction

endpackage

// File: rtl/core/mdr_cell.sv
// One channel cell of the state ring: staged setpoint, target, duty and enable.
`timescale 1ns / 1ps
module mdr_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mdr_pkg::ctrl_t                  ctrl,
    input  logic                            wr_en,
    input  logic [mdr_pkg::SP_W-1:0]        setpoint,
    input  mdr_pkg::chan_t                  shift_in,
    output mdr_pkg::chan_t                  state
);

    mdr_pkg::chan_t state_reg;
    mdr_pkg::chan_t state_next;
    logic [mdr_pkg::SP_W+4:0] scaled;

    assign scaled = (mdr_pkg::SP_W+5)'(state_reg.staged)
                  * (mdr_pkg::SP_W+5)'(mdr_pkg::SETPOINT_SCALE);

    always_comb begin
        state_next = state_reg;
        if (ctrl.shift) begin
            state_next = shift_in;
        end else begin
            if (wr_en) begin
                state_next.staged = setpoint;
            end
            if (ctrl.sync) begin
                state_next.target = mdr_pkg::DUTY_WIDTH'(scaled);
            end
            if (ctrl.start) begin
                state_next.enable = 1'b1;
            end
            if (ctrl.stop) begin
                state_next.enable = 1'b0;
                state_next.target = mdr_pkg::DUTY_WIDTH'(ctrl.stop_duty);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.staged <= '0;
            state_reg.target <= mdr_pkg::RESET_DUTY;
            state_reg.duty   <= mdr_pkg::RESET_DUTY;
            state_reg.enable <= 1'b0;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// File: rtl/core/mdr_step.sv
// Ramp step stage at the head of the ring: steps the head channel toward its target.
`timescale 1ns / 1ps
module mdr_step (
    input  mdr_pkg::chan_t                 head,
    input  logic [mdr_pkg::CNT_W-1:0]      idx,
    input  logic [mdr_pkg::GAIN_W-1:0]     gain_first,
    input  logic [mdr_pkg::GAIN_W-1:0]     gain_second,
    output mdr_pkg::chan_t                 stepped
);

    logic [mdr_pkg::GAIN_W-1:0] step;

    always_comb begin
        case (idx)
            mdr_pkg::CNT_W'(0): step = gain_first;
            mdr_pkg::CNT_W'(1): step = gain_second;
            default:            step = mdr_pkg::BASE_STEP;
        endcase
    end

    always_comb begin
        stepped      = head;
        stepped.duty = mdr_pkg::step_toward(head.duty, head.target, step);
    end

endmodule

// File: rtl/core/multichannel_duty_ramp.sv
// Top level of the multichannel PWM duty slew-rate limiter.
//
//  channel   direction  fields (lowest bit first)              transfer
//  s_axis    in         tdata: op[2:0] channel[6:3] setpoint[14:7]  tvalid & tready
//  m_axis    out        tdata: out_channel[3:0] duty[16:4] enabled[17]; tlast: last
//  cfg       in         cfg_index, cfg_wdata                   cfg_wr_en
//
//  Write, sync, start and stop update the cells as they are accepted and do not make the block busy.
//  A tick rotates the cell ring once, one result per cycle while the output is not stalled.
//  s_tready is low while the ring rotates; the next item is taken after the last result.
//  A stalled output register holds the ring in place.
//  Reset is synchronous and restores all channel state and the control and config registers, not the output data.
`timescale 1ns / 1ps
module multichannel_duty_ramp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mdr_pkg::S_DATA_W-1:0]      s_tdata,   // op, channel, setpoint
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mdr_pkg::M_DATA_W-1:0]      m_tdata,   // out_channel, duty, enabled
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [mdr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mdr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int N = mdr_pkg::NUM_CHANNELS;

    logic [mdr_pkg::GAIN_W-1:0] gain_first_reg;
    logic [mdr_pkg::GAIN_W-1:0] gain_second_reg;
    logic [mdr_pkg::STOP_W-1:0] stop_duty_reg;

    logic                       busy_reg, busy_next;
    logic [mdr_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       m_valid_reg, m_valid_next;
    logic [mdr_pkg::CH_W-1:0]   out_ch_reg;
    logic [mdr_pkg::OUT_DUTY_W-1:0] out_duty_reg;
    logic                       out_en_reg;
    logic                       out_last_reg;

    logic [mdr_pkg::OP_W-1:0]   in_op;
    logic [mdr_pkg::CH_W-1:0]   in_ch;
    logic [mdr_pkg::SP_W-1:0]   in_sp;
    logic                       accept;
    logic                       adv;
    logic                       walk;
    logic                       walk_end;

    mdr_pkg::ctrl_t             ctrl;
    mdr_pkg::chan_t             cells [N];
    mdr_pkg::chan_t             stepped;

    assign in_op = s_tdata[2:0];
    assign in_ch = s_tdata[6:3];
    assign in_sp = s_tdata[14:7];

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign adv      = !m_valid_reg || m_tready;
    assign walk     = busy_reg && adv;
    assign walk_end = walk && (cnt_reg == mdr_pkg::CNT_W'(N - 1));

    always_comb begin
        ctrl.shift     = walk;
        ctrl.sync      = accept && (in_op == mdr_pkg::OP_SYNC);
        ctrl.start     = accept && (in_op == mdr_pkg::OP_START);
        ctrl.stop      = accept && (in_op == mdr_pkg::OP_STOP);
        ctrl.stop_duty = stop_duty_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            logic wr_hit;
            assign wr_hit = accept && (in_op == mdr_pkg::OP_WRITE) && (32'(in_ch) == gi);
            mdr_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .wr_en    (wr_hit),
                .setpoint (in_sp),
                .shift_in ((gi == N - 1) ? stepped : cells[(gi + 1) % N]),
                .state    (cells[gi])
            );
        end
    endgenerate

    mdr_step u_step (
        .head        (cells[0]),
        .idx         (cnt_reg),
        .gain_first  (gain_first_reg),
        .gain_second (gain_second_reg),
        .stepped     (stepped)
    );

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (walk) begin
            cnt_next = cnt_reg + mdr_pkg::CNT_W'(1);
            if (walk_end) begin
                busy_next = 1'b0;
                cnt_next  = '0;
            end
        end else if (accept && (in_op == mdr_pkg::OP_TICK)) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (walk) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
            gain_first_reg  <= mdr_pkg::RESET_GAIN;
            gain_second_reg <= mdr_pkg::RESET_GAIN;
            stop_duty_reg   <= mdr_pkg::RESET_STOP;
        end else begin
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    mdr_pkg::CFG_GAIN_FIRST:  gain_first_reg  <= cfg_wdata[7:0];
                    mdr_pkg::CFG_GAIN_SECOND: gain_second_reg <= cfg_wdata[7:0];
                    mdr_pkg::CFG_STOP_DUTY:   stop_duty_reg   <= cfg_wdata;
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (walk) begin
            out_ch_reg   <= mdr_pkg::CH_W'(cnt_reg);
            out_duty_reg <= stepped.duty[mdr_pkg::OUT_DUTY_W-1:0];
            out_en_reg   <= stepped.enable;
            out_last_reg <= walk_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'b0, out_en_reg, out_duty_reg, out_ch_reg};

`ifndef SYNTH
    a_last_is_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (32'(out_ch_reg) == N - 1))
        else $error("tlast on a channel other than the highest");

    a_tick_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_op == mdr_pkg::OP_TICK)) |=> (busy_reg && (cnt_reg == '0)))
        else $error("tick did not start the ring walk");

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (cnt_reg == '0))
        else $error("walk counter nonzero while idle");

    a_stall_holds_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(cnt_reg))
        else $error("ring advanced while the output was stalled");
`endif

endmodule

// File: tb/duty_ramp_checker.sv
`timescale 1ns / 1ps
// Checker for the duty ramp block: tracks channel state and compares every channel report.
module duty_ramp_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [mdr_pkg::S_DATA_W-1:0]   s_tdata,   // op, channel, setpoint
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [mdr_pkg::M_DATA_W-1:0]   m_tdata,   // out_channel, duty, enabled
    input  logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic [mdr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mdr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             mismatches,
    output int                             pending
);
    import mdr_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0]       chan;
        logic [OUT_DUTY_W-1:0] duty;
        logic                  enabled;
        logic                  last;
    } duty_report_t;

    duty_report_t          expected_reports[$];

    logic [SP_W-1:0]       staged   [NUM_CHANNELS];
    logic [DUTY_WIDTH-1:0] target   [NUM_CHANNELS];
    logic [DUTY_WIDTH-1:0] duty     [NUM_CHANNELS];
    logic                  amp_en   [NUM_CHANNELS];
    logic [GAIN_W-1:0]     gain_first;
    logic [GAIN_W-1:0]     gain_second;
    logic [STOP_W-1:0]     stop_duty;

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic logic [DUTY_WIDTH-1:0] ramp_step(
        input logic [DUTY_WIDTH-1:0] cur,
        input logic [DUTY_WIDTH-1:0] tgt,
        input logic [GAIN_W-1:0]     gain
    );
        int unsigned c;
        int unsigned t;
        int unsigned g;
        c = 32'(cur);
        t = 32'(tgt);
        g = 32'(gain);
        if (t > c) begin
            return (c + g >= t) ? tgt : DUTY_WIDTH'(c + g);
        end
        if (t < c) begin
            return (c - t <= g) ? tgt : DUTY_WIDTH'(c - g);
        end
        return cur;
    endfunction

    task automatic check_field(input string field, input int chan, input int want,
                               input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s of channel %0d expected %0d actual %0d",
                     $time, field, chan, want, got);
        end
    endtask

    task automatic apply_item(input logic [S_DATA_W-1:0] item);
        logic [OP_W-1:0]   op;
        logic [CH_W-1:0]   ch;
        logic [SP_W-1:0]   sp;
        logic [GAIN_W-1:0] gain;
        duty_report_t      rep;
        op = item[OP_W-1:0];
        ch = item[OP_W +: CH_W];
        sp = item[OP_W+CH_W +: SP_W];
        case (op)
            OP_WRITE: begin
                if (ch < NUM_CHANNELS) staged[ch] = sp;
            end
            OP_SYNC: begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                    target[i] = DUTY_WIDTH'(staged[i] * SETPOINT_SCALE);
            end
            OP_TICK: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    gain = (i == 0) ? gain_first : (i == 1) ? gain_second : BASE_STEP;
                    duty[i]     = ramp_step(duty[i], target[i], gain);
                    rep.chan    = CH_W'(i);
                    rep.duty    = duty[i];
                    rep.enabled = amp_en[i];
                    rep.last    = (i == NUM_CHANNELS - 1);
                    expected_reports.push_back(rep);
                end
            end
            OP_START: begin
                for (int i = 0; i < NUM_CHANNELS; i++) amp_en[i] = 1'b1;
            end
            OP_STOP: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    amp_en[i] = 1'b0;
                    target[i] = stop_duty;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin : watch
        duty_report_t got;
        duty_report_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                staged[i] = '0;
                target[i] = RESET_DUTY;
                duty[i]   = RESET_DUTY;
                amp_en[i] = 1'b0;
            end
            gain_first  = RESET_GAIN;
            gain_second = RESET_GAIN;
            stop_duty   = RESET_STOP;
            expected_reports.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.chan    = m_tdata[CH_W-1:0];
                got.duty    = m_tdata[CH_W +: OUT_DUTY_W];
                got.enabled = m_tdata[CH_W+OUT_DUTY_W];
                got.last    = m_tlast;
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: report expected none actual channel %0d duty %0d",
                             $time, got.chan, got.duty);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("channel", int'(want.chan), int'(want.chan),
                                int'(got.chan));
                    check_field("duty", int'(want.chan), int'(want.duty),
                                int'(got.duty));
                    check_field("enabled", int'(want.chan), int'(want.enabled),
                                int'(got.enabled));
                    check_field("last", int'(want.chan), int'(want.last),
                                int'(got.last));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_GAIN_FIRST:  gain_first  = cfg_wdata[GAIN_W-1:0];
                    CFG_GAIN_SECOND: gain_second = cfg_wdata[GAIN_W-1:0];
                    CFG_STOP_DUTY:   stop_duty   = cfg_wdata[STOP_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) apply_item(s_tdata);
        end
        pending = expected_reports.size();
    end

endmodule

// File: tb/multichannel_duty_ramp_tb.sv
`timescale 1ns / 1ps
// Testbench top for the duty ramp block: clock, reset, stimulus, flow control and verdict.
module multichannel_duty_ramp_tb;
    import mdr_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;
    localparam int              LONG_HOLD     = 80;
    localparam int              PHASE_ITEMS   = 40;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    mismatches;
    int                    pending;

    bit tx_idle;
    bit rx_idle;
    int rx_hold;

    multichannel_duty_ramp dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    duty_ramp_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    initial begin
        #3_000_000;
        $display("FAIL multichannel_duty_ramp");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : sink
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = rx_idle ? $urandom_range(0, 5) : 0;
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                             input logic [SP_W-1:0] sp);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({sp, ch, op});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (NUM_CHANNELS + 4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_regs(input logic [GAIN_W-1:0] g0, input logic [GAIN_W-1:0] g1,
                             input logic [STOP_W-1:0] stop);
        wait_idle();
        write_reg(CFG_GAIN_FIRST, CFG_DATA_W'(g0));
        write_reg(CFG_GAIN_SECOND, CFG_DATA_W'(g1));
        write_reg(CFG_STOP_DUTY, CFG_DATA_W'(stop));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random(input int count);
        int               pick;
        logic [OP_W-1:0]  op;
        logic [CH_W-1:0]  ch;
        logic [SP_W-1:0]  sp;
        for (int k = 0; k < count; k++) begin
            if (k % 8 == 0) begin
                tx_idle = ($urandom_range(0, 2) != 0);
                rx_idle = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            ch   = CH_W'($urandom_range(0, 15));
            sp   = SP_W'($urandom_range(0, 255));
            if (pick < 45) begin
                op = OP_TICK;
            end else if (pick < 70) begin
                op = OP_WRITE;
                ch = ($urandom_range(0, 9) == 0) ? CH_W'($urandom_range(NUM_CHANNELS, 15))
                                                 : CH_W'($urandom_range(0, NUM_CHANNELS - 1));
            end else if (pick < 80) begin
                op = OP_SYNC;
            end else if (pick < 86) begin
                op = OP_START;
            end else if (pick < 93) begin
                op = OP_STOP;
            end else begin
                op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            end
            send_item(op, ch, sp);
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_GAIN_FIRST;
        cfg_wdata <= '0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // state straight out of reset
        send_item(OP_TICK, 4'd0, 8'd0);

        load_regs(8'd255, 8'd0, 13'd8191);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_item(OP_WRITE, 4'd0, 8'd255);
        send_item(OP_WRITE, 4'd1, 8'd0);
        send_item(OP_WRITE, 4'd11, 8'd170);
        send_item(OP_WRITE, 4'd12, 8'd85);
        send_item(OP_WRITE, 4'd15, 8'd255);
        send_item(OP_WRITE, 4'd5, 8'd1);
        send_item(OP_SYNC, 4'd0, 8'd0);
        send_item(OP_TICK, 4'd0, 8'd0);
        send_item(OP_TICK, 4'd15, 8'd255);
        send_item(OP_START, 4'd0, 8'd0);
        send_item(OP_TICK, 4'd0, 8'd0);
        send_item(OP_STOP, 4'd0, 8'd0);
        send_item(OP_TICK, 4'd0, 8'd0);
        send_item(OP_RSVD_FIRST, 4'd15, 8'd255);
        send_item(OP_RSVD_MID, 4'd3, 8'd0);
        send_item(OP_RSVD_LAST, 4'd15, 8'd255);
        send_item(OP_WRITE, 4'd1, 8'd255);
        send_item(OP_SYNC, 4'd0, 8'd0);
        send_item(OP_TICK, 4'd0, 8'd0);
        send_item(OP_TICK, 4'd0, 8'd0);
        send_random(PHASE_ITEMS);

        load_regs(8'd0, 8'd255, 13'd0);
        rx_hold = LONG_HOLD;
        send_random(PHASE_ITEMS);

        load_regs(GAIN_W'($urandom_range(0, 255)), GAIN_W'($urandom_range(0, 255)),
                  STOP_W'($urandom_range(0, 8191)));
        send_random(PHASE_ITEMS);

        load_regs(GAIN_W'($urandom_range(0, 255)), GAIN_W'($urandom_range(0, 255)),
                  STOP_W'($urandom_range(0, 8191)));
        send_random(PHASE_ITEMS);

        load_regs(8'd17, 8'd200, 13'd4095);
        send_random(PHASE_ITEMS);

        wait_idle();
        if (mismatches == 0) begin
            $display("PASS multichannel_duty_ramp");
        end else begin
            $display("FAIL multichannel_duty_ramp");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/mdr_pkg.sv
rtl/core/mdr_cell.sv
rtl/core/mdr_step.sv
rtl/core/multichannel_duty_ramp.sv
tb/duty_ramp_checker.sv
tb/multichannel_duty_ramp_tb.sv
